// ----- sv/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, types and helper functions for the C literal escaper.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CODE_BITS       = 21;
  localparam int LINE_COUNT_BITS = 10;
  localparam int MAXC_BITS       = 10;
  localparam int NIBBLES         = (CODE_BITS + 3) / 4;
  localparam int NIB_IDX_BITS    = (NIBBLES > 1) ? $clog2(NIBBLES) : 1;
  localparam int DIG_BITS        = $clog2(NIBBLES + 1);
  localparam int BREAK_LEN       = 4;
  localparam int BRK_IDX_BITS    = $clog2(BREAK_LEN);
  localparam int MAX_RESULTS     = 2 + NIBBLES + BREAK_LEN;
  localparam int LEN_BITS        = $clog2(MAX_RESULTS + 1);
  localparam int IDX_BITS        = $clog2(MAX_RESULTS);
  localparam int SUM_BITS        =
    ((LINE_COUNT_BITS > MAXC_BITS) ? LINE_COUNT_BITS : MAXC_BITS) + 1;
  localparam logic [SUM_BITS-1:0] CNT_MAX = SUM_BITS'((1 << LINE_COUNT_BITS) - 1);

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_HEX_LIMIT = 8'h10;

  localparam logic [BREAK_LEN-1:0][7:0] BREAK_SEQ = {CH_DQ, CH_LF, CH_CR, CH_DQ};

  typedef enum logic [1:0] {
    REG_MAX_CHARS   = 2'd0,
    REG_BREAK_NL    = 2'd1,
    REG_REPLACE_SQ  = 2'd2,
    REG_NUL_TERM    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MAXC_BITS-1:0] max_chars_on_line;
    logic                 break_at_newlines;
    logic                 replace_single_quotes;
    logic                 nul_terminated;
  } cfg_t;

  typedef struct packed {
    logic [LINE_COUNT_BITS-1:0] line_char_count;
    logic                       after_hex_escape;
  } line_state_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [LEN_BITS-1:0]         len;
  } burst_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + 8'(v);
    end else begin
      r = 8'h61 + 8'(v - 4'd10);
    end
    return r;
  endfunction

  function automatic logic is_hex_char(input logic [CODE_BITS-1:0] c);
    return (c >= CODE_BITS'(8'h30) && c <= CODE_BITS'(8'h39)) ||
           (c >= CODE_BITS'(8'h61) && c <= CODE_BITS'(8'h66)) ||
           (c >= CODE_BITS'(8'h41) && c <= CODE_BITS'(8'h46));
  endfunction

endpackage

// ----- sv/cle_if.sv -----
// ----------------------------------------------------------------------------
// cle_if
// Valid/ready channel interfaces for character input and byte output.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic                          valid;
  logic                          ready;
  logic [cle_pkg::CODE_BITS-1:0] char_code;
  logic                          is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink (input valid, input char_code, input is_final, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- sv/cle_expand.sv -----
// ----------------------------------------------------------------------------
// cle_expand
// Expands one character code into its escaped byte sequence and line break,
// and computes the next line state.
// ----------------------------------------------------------------------------
module cle_expand (
  input  logic [cle_pkg::CODE_BITS-1:0] char_code,
  input  logic                          is_final,
  input  cle_pkg::cfg_t                 cfg,
  input  cle_pkg::line_state_t          state,
  output cle_pkg::burst_t               burst,
  output cle_pkg::line_state_t          state_next
);

  logic [cle_pkg::NIBBLES*4-1:0]      code_pad;
  logic                               final_item;
  logic                               simple_esc;
  logic                               printable;
  logic                               is_lf;
  logic                               new_line;
  logic                               do_break;
  logic                               ahe_next;
  logic [7:0]                         esc_byte;
  logic [cle_pkg::DIG_BITS-1:0]       digits;
  logic [cle_pkg::NIB_IDX_BITS-1:0]   nib_sel;
  logic [cle_pkg::BRK_IDX_BITS-1:0]   brk_sel;
  logic [cle_pkg::LEN_BITS-1:0]       len0;
  logic [cle_pkg::SUM_BITS-1:0]       cnt_sum;
  logic [cle_pkg::LINE_COUNT_BITS-1:0] cnt_next;
  logic [cle_pkg::MAX_RESULTS-1:0][7:0] data;

  assign code_pad   = (cle_pkg::NIBBLES*4)'(char_code);
  assign final_item = is_final && !cfg.nul_terminated;
  assign is_lf      = char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_LF);
  assign simple_esc = char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_TAB) ||
                      char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_CR) || is_lf ||
                      char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_BSL) ||
                      char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_DQ) ||
                      (char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_SQ) &&
                       cfg.replace_single_quotes);
  assign printable  = char_code >= cle_pkg::CODE_BITS'(cle_pkg::CH_SPACE) &&
                      char_code < cle_pkg::CODE_BITS'(cle_pkg::CH_DEL) &&
                      !(state.after_hex_escape && cle_pkg::is_hex_char(char_code));

  always_comb begin
    if (char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_TAB)) begin
      esc_byte = cle_pkg::CH_T;
    end else if (char_code == cle_pkg::CODE_BITS'(cle_pkg::CH_CR)) begin
      esc_byte = cle_pkg::CH_R;
    end else if (is_lf) begin
      esc_byte = cle_pkg::CH_N;
    end else begin
      esc_byte = char_code[7:0];
    end
  end

  // number of significant hex digits
  always_comb begin
    digits = cle_pkg::DIG_BITS'(1);
    for (int k = 0; k < cle_pkg::NIBBLES; k++) begin
      if (code_pad[4*k +: 4] != 4'd0) begin
        digits = cle_pkg::DIG_BITS'(k + 1);
      end
    end
  end

  // character bytes
  always_comb begin
    data     = '0;
    len0     = '0;
    ahe_next = 1'b0;
    nib_sel  = '0;
    data[0]  = cle_pkg::CH_BSL;
    if (simple_esc) begin
      data[1] = esc_byte;
      len0    = cle_pkg::LEN_BITS'(2);
    end else if (char_code == '0) begin
      data[1]  = cle_pkg::CH_ZERO;
      len0     = cle_pkg::LEN_BITS'(2);
      ahe_next = 1'b1;
    end else if (printable) begin
      data[0] = char_code[7:0];
      len0    = cle_pkg::LEN_BITS'(1);
    end else if (char_code < cle_pkg::CODE_BITS'(cle_pkg::CH_HEX_LIMIT)) begin
      data[1]  = cle_pkg::CH_X;
      data[2]  = cle_pkg::CH_ZERO;
      data[3]  = cle_pkg::hex_digit(code_pad[3:0]);
      len0     = cle_pkg::LEN_BITS'(4);
      ahe_next = 1'b1;
    end else begin
      data[1]  = cle_pkg::CH_X;
      len0     = cle_pkg::LEN_BITS'(2 + int'(digits));
      ahe_next = 1'b1;
      for (int k = 0; k < cle_pkg::NIBBLES; k++) begin
        if (k < int'(digits)) begin
          nib_sel     = cle_pkg::NIB_IDX_BITS'(int'(digits) - 1 - k);
          data[2 + k] = cle_pkg::hex_digit(code_pad[4*nib_sel +: 4]);
        end
      end
    end
  end

  // line counter and break decision
  assign new_line = is_lf && cfg.break_at_newlines;

  always_comb begin
    do_break = 1'b0;
    cnt_sum  = '0;
    cnt_next = state.line_char_count;
    if (new_line) begin
      do_break = 1'b1;
    end else if (cfg.max_chars_on_line != '0) begin
      cnt_sum = cle_pkg::SUM_BITS'(state.line_char_count) + cle_pkg::SUM_BITS'(1);
      if (cnt_sum >= cle_pkg::SUM_BITS'(cfg.max_chars_on_line)) begin
        do_break = 1'b1;
        cnt_sum  = cle_pkg::SUM_BITS'(cfg.max_chars_on_line);
      end
      if (cnt_sum > cle_pkg::CNT_MAX) begin
        cnt_sum = cle_pkg::CNT_MAX;
      end
      cnt_next = cnt_sum[cle_pkg::LINE_COUNT_BITS-1:0];
    end
  end

  // break append and final state
  always_comb begin
    burst.data = data;
    burst.len  = len0;
    brk_sel    = '0;
    state_next.line_char_count  = cnt_next;
    state_next.after_hex_escape = ahe_next;
    if (do_break && !final_item) begin
      state_next.line_char_count = '0;
      burst.len = len0 + cle_pkg::LEN_BITS'(cle_pkg::BREAK_LEN);
      for (int p = 0; p < cle_pkg::MAX_RESULTS; p++) begin
        if (p >= int'(len0) && p < int'(len0) + cle_pkg::BREAK_LEN) begin
          brk_sel       = cle_pkg::BRK_IDX_BITS'(p - int'(len0));
          burst.data[p] = cle_pkg::BREAK_SEQ[brk_sel];
        end
      end
    end
    if (final_item) begin
      state_next = '0;
    end
    if (char_code == '0 && cfg.nul_terminated) begin
      burst.len  = '0;
      state_next = '0;
    end
  end

endmodule

// ----- sv/c_literal_escaper_core.sv -----
// ----------------------------------------------------------------------------
// c_literal_escaper_core
// C string-literal escaper: one character code in, its escaped bytes out.
// ----------------------------------------------------------------------------
// char_in carries one character code per transaction; byte_out carries one
// escaped byte per transaction, with run_last high on the last byte of each
// character. The APB port sets line length, newline breaks, single-quote
// escaping and NUL-terminated mode; write it only while the block is idle.
// An accepted character is expanded combinationally into a burst register
// of up to 12 bytes; the first byte is offered on byte_out the next cycle.
// Plain characters stream at one per cycle while byte_out is ready; an escape
// holds the output until all of its bytes have left. The next character is
// taken in the cycle the last byte of the current burst leaves. A NUL in
// terminated mode yields no byte and only clears the line state. When
// byte_out stalls, the burst holds and char_in is held off. Reset clears
// the burst valid flag and index and the line state, and loads the
// register defaults.
// ----------------------------------------------------------------------------
module c_literal_escaper_core (
  input  logic                           clk,
  input  logic                           rst,
  cle_in_if.sink                         char_in,
  cle_out_if.source                      byte_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cle_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [cle_pkg::DATA_BITS-1:0]  pwdata,
  output logic [cle_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  cle_pkg::cfg_t                 cfg;
  cle_pkg::line_state_t          state;
  cle_pkg::line_state_t          state_next;
  cle_pkg::burst_t               burst;
  cle_pkg::burst_t               burst_next;
  logic                          bvalid;
  logic [cle_pkg::IDX_BITS-1:0]  idx;
  logic                          out_fire;
  logic                          last_take;
  logic                          in_fire;
  logic                          cfg_write;
  cle_pkg::cfg_reg_t             reg_sel;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = cle_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_chars_on_line     <= cle_pkg::MAXC_BITS'(250);
      cfg.break_at_newlines     <= 1'b0;
      cfg.replace_single_quotes <= 1'b1;
      cfg.nul_terminated        <= 1'b1;
    end else if (cfg_write) begin
      case (reg_sel)
        cle_pkg::REG_MAX_CHARS:  cfg.max_chars_on_line     <= pwdata[cle_pkg::MAXC_BITS-1:0];
        cle_pkg::REG_BREAK_NL:   cfg.break_at_newlines     <= pwdata[0];
        cle_pkg::REG_REPLACE_SQ: cfg.replace_single_quotes <= pwdata[0];
        cle_pkg::REG_NUL_TERM:   cfg.nul_terminated        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cle_pkg::REG_MAX_CHARS:  prdata = cle_pkg::DATA_BITS'(cfg.max_chars_on_line);
      cle_pkg::REG_BREAK_NL:   prdata = cle_pkg::DATA_BITS'(cfg.break_at_newlines);
      cle_pkg::REG_REPLACE_SQ: prdata = cle_pkg::DATA_BITS'(cfg.replace_single_quotes);
      cle_pkg::REG_NUL_TERM:   prdata = cle_pkg::DATA_BITS'(cfg.nul_terminated);
      default:                 prdata = '0;
    endcase
  end

  // expansion
  cle_expand u_expand (
    .char_code  (char_in.char_code),
    .is_final   (char_in.is_final),
    .cfg        (cfg),
    .state      (state),
    .burst      (burst_next),
    .state_next (state_next)
  );

  // handshakes
  assign out_fire      = bvalid && byte_out.ready;
  assign last_take     = out_fire && (cle_pkg::LEN_BITS'(idx) + 1'b1 == burst.len);
  assign char_in.ready = !bvalid || last_take;
  assign in_fire       = char_in.valid && char_in.ready;

  assign byte_out.valid    = bvalid;
  assign byte_out.out_byte = burst.data[idx];
  assign byte_out.run_last = cle_pkg::LEN_BITS'(idx) + 1'b1 == burst.len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '0;
      bvalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (in_fire) begin
        state <= state_next;
      end
      if (in_fire && burst_next.len != '0) begin
        bvalid <= 1'b1;
        idx    <= '0;
      end else if (last_take) begin
        bvalid <= 1'b0;
        idx    <= '0;
      end else if (out_fire) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && burst_next.len != '0) begin
      burst <= burst_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    bvalid |-> (burst.len != '0 &&
                burst.len <= cle_pkg::LEN_BITS'(cle_pkg::MAX_RESULTS)))
    else $error("burst length out of range");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    bvalid |-> (cle_pkg::LEN_BITS'(idx) < burst.len))
    else $error("byte index past burst end");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (byte_out.valid && byte_out.ready && !byte_out.run_last) |=> byte_out.valid)
    else $error("burst dropped before its last byte");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready && bvalid) |-> byte_out.run_last)
    else $error("new transaction accepted over an unfinished burst");
`endif

endmodule

// ----- tb/c_literal_escaper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_literal_escaper_core_test
// Self-checking testbench for the C string-literal escaper core.
// A scoreboard predicts the escaped byte stream for every accepted character,
// tracking line length and hex-escape state, and compares it byte by byte
// with byte_out. Directed characters cover escapes, hex forms, NUL handling
// and line breaks; random streams run under several register settings with
// random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module c_literal_escaper_core_test;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } esc_byte_t;

  class escape_scoreboard;
    esc_byte_t                           expected_bytes[$];
    logic [cle_pkg::MAXC_BITS-1:0]       max_chars;
    logic                                brk_nl;
    logic                                repl_sq;
    logic                                nul_term;
    logic [cle_pkg::LINE_COUNT_BITS-1:0] line_count;
    logic                                after_hex;
    int                                  errors;

    function new();
      max_chars  = cle_pkg::MAXC_BITS'(250);
      brk_nl     = 1'b0;
      repl_sq    = 1'b1;
      nul_term   = 1'b1;
      line_count = '0;
      after_hex  = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cle_pkg::cfg_reg_t idx, logic [cle_pkg::DATA_BITS-1:0] v);
      case (idx)
        cle_pkg::REG_MAX_CHARS:  max_chars = v[cle_pkg::MAXC_BITS-1:0];
        cle_pkg::REG_BREAK_NL:   brk_nl = v[0];
        cle_pkg::REG_REPLACE_SQ: repl_sq = v[0];
        cle_pkg::REG_NUL_TERM:   nul_term = v[0];
        default: ;
      endcase
    endfunction

    function void note_char(logic [cle_pkg::CODE_BITS-1:0] code, logic fin);
      logic [7:0]  seq[$];
      logic [7:0]  esc;
      logic [3:0]  nib;
      logic        final_item;
      logic        nl_break;
      logic        do_break;
      logic        hex_like;
      int          digits;
      int unsigned next_count;
      esc_byte_t   e;
      final_item = fin && !nul_term;
      nl_break = 1'b0;
      do_break = 1'b0;
      if (code == 0 && nul_term) begin
        line_count = '0;
        after_hex = 1'b0;
        return;
      end
      hex_like = (code >= cle_pkg::CH_ZERO && code <= 8'h39) ||
                 (code >= 8'h61 && code <= 8'h66) || (code >= 8'h41 && code <= 8'h46);
      if (code == cle_pkg::CH_TAB || code == cle_pkg::CH_CR || code == cle_pkg::CH_LF ||
          code == cle_pkg::CH_BSL || code == cle_pkg::CH_DQ ||
          (code == cle_pkg::CH_SQ && repl_sq)) begin
        esc = (code == cle_pkg::CH_TAB) ? cle_pkg::CH_T : (code == cle_pkg::CH_CR) ?
              cle_pkg::CH_R : (code == cle_pkg::CH_LF) ? cle_pkg::CH_N : code[7:0];
        seq.push_back(cle_pkg::CH_BSL);
        seq.push_back(esc);
        after_hex = 1'b0;
        nl_break = (code == cle_pkg::CH_LF) && brk_nl;
      end else if (code == 0) begin
        seq.push_back(cle_pkg::CH_BSL);
        seq.push_back(cle_pkg::CH_ZERO);
        after_hex = 1'b1;
      end else if (code >= cle_pkg::CH_SPACE && code < cle_pkg::CH_DEL &&
                   !(after_hex && hex_like)) begin
        seq.push_back(code[7:0]);
        after_hex = 1'b0;
      end else begin
        digits = 1;
        while (digits < 8 && (code >> (4 * digits)) != 0) digits++;
        seq.push_back(cle_pkg::CH_BSL);
        seq.push_back(cle_pkg::CH_X);
        if (code < cle_pkg::CH_HEX_LIMIT) seq.push_back(cle_pkg::CH_ZERO);
        for (int k = digits - 1; k >= 0; k--) begin
          nib = 4'(code >> (4 * k));
          seq.push_back((nib < 4'd10) ? cle_pkg::CH_ZERO + 8'(nib) : 8'h61 + 8'(nib - 4'd10));
        end
        after_hex = 1'b1;
      end
      if (nl_break) begin
        do_break = 1'b1;
      end else if (max_chars != 0) begin
        next_count = line_count + 1;
        if (next_count >= max_chars) begin
          do_break = 1'b1;
          next_count = max_chars;
        end
        if (next_count > (1 << cle_pkg::LINE_COUNT_BITS) - 1) begin
          next_count = (1 << cle_pkg::LINE_COUNT_BITS) - 1;
        end
        line_count = cle_pkg::LINE_COUNT_BITS'(next_count);
      end
      if (do_break && !final_item) begin
        line_count = '0;
        seq.push_back(cle_pkg::CH_DQ);
        seq.push_back(cle_pkg::CH_CR);
        seq.push_back(cle_pkg::CH_LF);
        seq.push_back(cle_pkg::CH_DQ);
      end
      if (final_item) begin
        line_count = '0;
        after_hex = 1'b0;
      end
      foreach (seq[i]) begin
        e.value = seq[i];
        e.last = (i == seq.size() - 1);
        expected_bytes.push_back(e);
      end
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      esc_byte_t e;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual out_byte %02h run_last %0b",
                 $time, b, last);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.value) begin
        $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, e.value, b);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: run_last mismatch: expected %0b, actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cle_pkg::ADDR_BITS-1:0] paddr;
  logic [cle_pkg::DATA_BITS-1:0] pwdata;
  logic [cle_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;
  bit                            quiet;
  int                            hold_requests;
  int                            hold_served;
  int                            hold_left;
  int                            stall_left;
  escape_scoreboard              sb = new();

  cle_in_if  char_in();
  cle_out_if byte_out();

  c_literal_escaper_core uut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in.sink),
    .byte_out (byte_out.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // output side: checks every transaction and stalls at random
  initial begin
    hold_served = 0;
    hold_left = 0;
    stall_left = 0;
    byte_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && byte_out.valid && byte_out.ready) begin
        sb.check_byte(byte_out.out_byte, byte_out.run_last);
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        byte_out.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        byte_out.ready <= 1'b0;
      end else begin
        byte_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [cle_pkg::CODE_BITS-1:0] code, input logic fin);
    char_in.valid <= 1'b1;
    char_in.char_code <= code;
    char_in.is_final <= fin;
    do @(posedge clk); while (!char_in.ready);
    sb.note_char(code, fin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      char_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    char_in.valid <= 1'b0;
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(input cle_pkg::cfg_reg_t idx,
                           input logic [cle_pkg::DATA_BITS-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= cle_pkg::ADDR_BITS'(4 * int'(idx));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
  endtask

  task automatic write_config(input int max_chars, input bit brk_nl, input bit repl_sq,
                              input bit nul_term);
    apb_write(cle_pkg::REG_MAX_CHARS, cle_pkg::DATA_BITS'(max_chars));
    apb_write(cle_pkg::REG_BREAK_NL, cle_pkg::DATA_BITS'(brk_nl));
    apb_write(cle_pkg::REG_REPLACE_SQ, cle_pkg::DATA_BITS'(repl_sq));
    apb_write(cle_pkg::REG_NUL_TERM, cle_pkg::DATA_BITS'(nul_term));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [cle_pkg::CODE_BITS-1:0] random_char();
    int unsigned pick;
    logic [cle_pkg::CODE_BITS-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c = cle_pkg::CODE_BITS'($urandom_range(32, 126));
    end else if (pick < 45) begin
      case ($urandom_range(0, 5))
        0: c = cle_pkg::CODE_BITS'(cle_pkg::CH_TAB);
        1: c = cle_pkg::CODE_BITS'(cle_pkg::CH_CR);
        2: c = cle_pkg::CODE_BITS'(cle_pkg::CH_LF);
        3: c = cle_pkg::CODE_BITS'(cle_pkg::CH_BSL);
        4: c = cle_pkg::CODE_BITS'(cle_pkg::CH_DQ);
        default: c = cle_pkg::CODE_BITS'(cle_pkg::CH_SQ);
      endcase
    end else if (pick < 60) begin
      case ($urandom_range(0, 2))
        0: c = cle_pkg::CODE_BITS'($urandom_range(48, 57));
        1: c = cle_pkg::CODE_BITS'($urandom_range(97, 102));
        default: c = cle_pkg::CODE_BITS'($urandom_range(65, 70));
      endcase
    end else if (pick < 75) begin
      c = cle_pkg::CODE_BITS'($urandom_range(0, 1) ? $urandom_range(1, 31) :
                                                     $urandom_range(127, 255));
    end else if (pick < 92) begin
      c = cle_pkg::CODE_BITS'($urandom_range(256, 1114111));
    end else begin
      c = '0;
    end
    return c;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_char(random_char(), $urandom_range(0, 11) == 0);
  endtask

  int first_codes[] = '{65, 9, 13, 10, 92, 34, 39, 32, 126, 127, 1, 1114111, 52, 70,
                        128, 0, 53, 90, 1048576};
  bit first_final[] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0};
  int counted_codes[] = '{0, 55, 39, 10, 97, 98};
  bit counted_final[] = '{0, 0, 0, 0, 0, 1};

  initial begin
    quiet = 1'b0;
    hold_requests = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    char_in.valid <= 1'b0;
    char_in.char_code <= '0;
    char_in.is_final <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: terminated mode, single quote escaped
    foreach (first_codes[i]) begin
      send_char(cle_pkg::CODE_BITS'(first_codes[i]), first_final[i]);
    end
    wait_idle();

    // counted mode, short lines, newline breaks
    write_config(2, 1'b1, 1'b0, 1'b0);
    foreach (counted_codes[i]) begin
      send_char(cle_pkg::CODE_BITS'(counted_codes[i]), counted_final[i]);
    end
    hold_requests++;
    run_random(50);
    wait_idle();

    write_config(0, 1'b0, 1'b1, 1'b1);
    run_random(45);
    wait_idle();

    write_config(1023, 1'b1, 1'b1, 1'b0);
    run_random(45);
    wait_idle();

    write_config(1, 1'b0, 1'b0, 1'b1);
    run_random(45);
    wait_idle();

    write_config($urandom_range(0, 8), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1));
    run_random(45);
    wait_idle();

    write_config($urandom_range(2, 12), $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
    quiet = 1'b1;
    run_random(80);
    wait_idle();

    if (sb.pending() != 0) begin
      $display("%0t: leftover: expected %0d more bytes, actual none", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
